[sv/rsp_pkg.sv]
// Package with result codes and the piece record for the rectangle subtractor.
`default_nettype none

package rsp_pkg;

	// Result status codes
	localparam logic [1:0] ST_NO_OVERLAP = 2'd0;
	localparam logic [1:0] ST_PIECE      = 2'd1;
	localparam logic [1:0] ST_COVERED    = 2'd2;

	// Remainder piece positions, in emission order
	localparam logic [1:0] SIDE_TOP    = 2'd0;
	localparam logic [1:0] SIDE_LEFT   = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;
	localparam logic [1:0] SIDE_BOTTOM = 2'd3;

	localparam int NUM_SIDES = 4;

	// One result rectangle
	typedef struct packed {
		logic [15:0] h;
		logic [15:0] w;
		logic [15:0] y;
		logic [15:0] x;
	} piece_t;

endpackage

`default_nettype wire

[sv/rectangle_subtract_pieces.sv]
// Rectangle subtractor: removes an occluder from a visible rectangle, emits remainder pieces.
//
// Input channel s_*: one item per handshake holds a visible and an occluding rectangle.
// Output channel m_*: one item per result rectangle; m_tlast marks the final result
// of each input item. With no overlap a single item echoes the visible rectangle
// (status no-overlap); with full cover a single all-zero item has status covered.
// Otherwise the top, left, right and bottom remainder pieces that exist follow in
// that order.
//
// The first result of an item passes three compute stages, the piece sequencer and
// the output register, in that order.
// Throughput: the compute stages take an item every cycle unless a stall holds them;
// the piece sequencer sends one result per cycle while the output is not stalled, and
// takes the next item as the last of the current item's one to four results is sent.
//
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver holds m_tready low the output register holds its item and the
// stall backs up stage by stage; s_tready falls only when the three compute stages and
// the sequencer are full. Nothing is dropped or repeated.
`default_nettype none

module rectangle_subtract_pieces
	import rsp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// vis_x[15:0] vis_y[31:16] vis_w[46:32] vis_h[61:47]
	// occ_x[77:62] occ_y[93:78] occ_w[108:94] occ_h[123:109], zero pad [127:124]
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// piece_x[15:0] piece_y[31:16] piece_w[47:32] piece_h[63:48]
	output logic [63:0]       m_tdata,
	// status[1:0] side[3:2]
	output logic [3:0]        m_tuser,
	output logic              m_tlast
);

	// Stage handshake
	logic rdy_s1, rdy_s2, rdy_s3, e_ready, out_load;
	logic v_s1, v_s2, v_s3;

	// Stage 1 registers
	logic signed [15:0] vx_s1, vy_s1, ox_s1, oy_s1;
	logic [14:0]        vw_s1, vh_s1;
	logic signed [16:0] vr_s1, vb_s1, or_s1, ob_s1;

	// Stage 2 registers
	logic               ovl_s2;
	logic [3:0]         have_s2;
	logic [15:0]        vx_s2, vy_s2, by_s2, minb_s2, or_s2, ob_s2;
	logic [14:0]        vw_s2, vh_s2;
	logic [15:0]        top_h_s2, left_w_s2, right_w_s2, bot_h_s2;

	// Stage 2 combinational
	logic signed [16:0] vx_e, vy_e, ox_e, oy_e;
	logic               ovl_c;
	logic signed [15:0] by_c;
	logic signed [16:0] minb_c;

	// Stage 3 registers
	logic [1:0]         status_s3;
	logic [3:0]         mask_s3;
	piece_t             slot_s3 [NUM_SIDES];
	logic [15:0]        bh_c;

	// Sequencer registers
	logic               e_valid_q;
	logic [1:0]         e_status_q;
	logic [3:0]         e_mask_q;
	piece_t             e_slot_q [NUM_SIDES];
	logic [1:0]         sel_c;
	logic [3:0]         sel_oh_c;
	logic               e_last_c;

	// Output register
	logic               out_valid_q;
	piece_t             out_piece_q;
	logic [1:0]         out_status_q, out_side_q;
	logic               out_last_q;

	// Ready flows back from the output register
	assign out_load = e_valid_q && (!out_valid_q || m_tready);
	assign e_ready  = !e_valid_q || (out_load && e_last_c);
	assign rdy_s3   = !v_s3 || e_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: unpack and form far edges one bit wider
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			vx_s1 <= s_tdata[15:0];
			vy_s1 <= s_tdata[31:16];
			vw_s1 <= s_tdata[46:32];
			vh_s1 <= s_tdata[61:47];
			ox_s1 <= s_tdata[77:62];
			oy_s1 <= s_tdata[93:78];
			vr_s1 <= $signed({s_tdata[15], s_tdata[15:0]}) + $signed({2'b00, s_tdata[46:32]});
			vb_s1 <= $signed({s_tdata[31], s_tdata[31:16]}) + $signed({2'b00, s_tdata[61:47]});
			or_s1 <= $signed({s_tdata[77], s_tdata[77:62]}) + $signed({2'b00, s_tdata[108:94]});
			ob_s1 <= $signed({s_tdata[93], s_tdata[93:78]})
				+ $signed({2'b00, s_tdata[123:109]});
		end
	end

	// Stage 2: overlap test, side presence, band limits and piece extents
	assign vx_e   = {vx_s1[15], vx_s1};
	assign vy_e   = {vy_s1[15], vy_s1};
	assign ox_e   = {ox_s1[15], ox_s1};
	assign oy_e   = {oy_s1[15], oy_s1};
	assign ovl_c  = (ox_e < vr_s1) && (or_s1 > vx_e) && (oy_e < vb_s1) && (ob_s1 > vy_e);
	assign by_c   = (vy_s1 > oy_s1) ? vy_s1 : oy_s1;
	assign minb_c = (vb_s1 < ob_s1) ? vb_s1 : ob_s1;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ovl_s2     <= ovl_c;
			have_s2[SIDE_TOP]    <= oy_s1 > vy_s1;
			have_s2[SIDE_LEFT]   <= ox_s1 > vx_s1;
			have_s2[SIDE_RIGHT]  <= or_s1 < vr_s1;
			have_s2[SIDE_BOTTOM] <= ob_s1 < vb_s1;
			vx_s2      <= vx_s1;
			vy_s2      <= vy_s1;
			vw_s2      <= vw_s1;
			vh_s2      <= vh_s1;
			by_s2      <= by_c;
			minb_s2    <= minb_c[15:0];
			or_s2      <= or_s1[15:0];
			ob_s2      <= ob_s1[15:0];
			top_h_s2   <= oy_s1 - vy_s1;
			left_w_s2  <= ox_s1 - vx_s1;
			right_w_s2 <= vr_s1[15:0] - or_s1[15:0];
			bot_h_s2   <= vb_s1[15:0] - ob_s1[15:0];
		end
	end

	// Stage 3: band height and the result slots
	assign bh_c = minb_s2 - by_s2;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			if (!ovl_s2) begin
				status_s3  <= ST_NO_OVERLAP;
				mask_s3    <= 4'b0001;
				slot_s3[0] <= '{h: {1'b0, vh_s2}, w: {1'b0, vw_s2}, y: vy_s2, x: vx_s2};
			end else if (have_s2 == 4'b0000) begin
				status_s3  <= ST_COVERED;
				mask_s3    <= 4'b0001;
				slot_s3[0] <= '0;
			end else begin
				status_s3  <= ST_PIECE;
				mask_s3    <= have_s2;
				slot_s3[0] <= '{h: top_h_s2, w: {1'b0, vw_s2}, y: vy_s2, x: vx_s2};
			end
			slot_s3[1] <= '{h: bh_c, w: left_w_s2, y: by_s2, x: vx_s2};
			slot_s3[2] <= '{h: bh_c, w: right_w_s2, y: by_s2, x: or_s2};
			slot_s3[3] <= '{h: bot_h_s2, w: {1'b0, vw_s2}, y: ob_s2, x: vx_s2};
		end
	end

	// Pick the lowest pending slot
	always_comb begin
		if (e_mask_q[0]) begin
			sel_c = SIDE_TOP;
		end else if (e_mask_q[1]) begin
			sel_c = SIDE_LEFT;
		end else if (e_mask_q[2]) begin
			sel_c = SIDE_RIGHT;
		end else begin
			sel_c = SIDE_BOTTOM;
		end
	end
	assign sel_oh_c = 4'b0001 << sel_c;
	assign e_last_c = (e_mask_q & ~sel_oh_c) == 4'b0000;

	// Sequencer: hold one item and send its pieces one per cycle while the output accepts them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q <= 1'b0;
		end else if (e_ready) begin
			e_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (e_ready && v_s3) begin
			e_status_q <= status_s3;
			e_mask_q   <= mask_s3;
			e_slot_q   <= slot_s3;
		end else if (out_load) begin
			e_mask_q   <= e_mask_q & ~sel_oh_c;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= e_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_piece_q  <= e_slot_q[sel_c];
			out_status_q <= e_status_q;
			out_side_q   <= sel_c;
			out_last_q   <= e_last_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_piece_q.h, out_piece_q.w, out_piece_q.y, out_piece_q.x};
	assign m_tuser  = {out_side_q, out_status_q};
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// A held item always has a piece left to send
	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid_q |-> (e_mask_q != 4'b0000))
		else $error("sequencer holds an item with no pending piece");

	// Echo and covered items carry exactly one result
	a_single_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(e_valid_q && (e_status_q != ST_PIECE)) |-> (e_mask_q == 4'b0001))
		else $error("single-result item has more than one slot pending");

	// Echo and covered results close their item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_PIECE)) |-> out_last_q)
		else $error("single result without last mark");

	// Input backs up only when all compute stages are full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && e_valid_q))
		else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
